>>> hw/rtl/lca_pkg.sv
// Shared types and constants for the life cellular automaton step unit.
// No dependencies; every other file in the block but lca_ram imports this package.
package lca_pkg;

	localparam int ACTION_W   = 2;
	localparam int INDEX_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0]  REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_DATA_W-1:0] RESET_SIDE      = 7'd64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_ADVANCE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GEN,
		ST_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic acc;
		logic gen_start;
		logic row_shift;
		logic gen_rd;
		logic gen_load;
		logic gen_wr;
		logic flip;
		logic rsp_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic dims_busy;
		logic rsp_free;
	} sts_t;

endpackage

>>> hw/rtl/lca_if.sv
// Handshake channels of the life cellular automaton step unit: request,
// response and configuration write. Depends on lca_pkg for field widths.
interface lca_req_if;
	import lca_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  cell_index;
	logic                cell_value;
	modport source(output valid, action, cell_index, cell_value, input ready);
	modport sink(input valid, action, cell_index, cell_value, output ready);
endinterface

interface lca_rsp_if;
	logic valid;
	logic ready;
	logic read_value;
	modport source(output valid, read_value, input ready);
	modport sink(input valid, read_value, output ready);
endinterface

interface lca_cfg_if;
	import lca_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/lca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/lca_ctrl.sv
// Controller of the life step unit: state machine, generation sweep counters
// and the command strobes for the datapath. Depends on lca_pkg.
module lca_ctrl #(
	parameter int MAX_SIDE = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [lca_pkg::ACTION_W-1:0]      req_action,
	output logic                              req_ready,
	input  lca_pkg::sts_t                     sts,
	input  logic [$clog2(MAX_SIDE+1)-1:0]     ew,
	input  logic [$clog2(MAX_SIDE+1)-1:0]     eh,
	output lca_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_SIDE+3)-1:0]     col
);
	import lca_pkg::*;

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE + 3);

	state_t          state_q, state_nxt;
	logic [CW-1:0]   col_q;
	logic [SW-1:0]   pass_q;
	logic [CW-1:0]   ew_c;
	logic            last_col;
	logic            last_pass;
	logic            pass_rd;
	logic            pass_wr;
	logic            accept;

	assign ew_c      = CW'(ew);
	assign last_col  = (col_q == ew_c + CW'(2));
	assign last_pass = (pass_q == eh);
	assign pass_rd   = (pass_q < eh);
	assign pass_wr   = (pass_q != '0);
	assign accept    = req_valid && req_ready;
	assign col       = col_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (req_action == ACT_ADVANCE) ? ST_GEN : ST_RESP;
				end
			end
			ST_GEN: begin
				if (last_col && last_pass) state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (sts.rsp_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				req_ready     = !sts.dims_busy;
				cmd.acc       = req_valid && !sts.dims_busy;
				cmd.gen_start = cmd.acc && (req_action == ACT_ADVANCE);
			end
			ST_GEN: begin
				// Read row pass_q while writing row pass_q-1, three columns behind
				cmd.row_shift = (col_q == '0);
				cmd.gen_rd    = pass_rd && (col_q < ew_c);
				cmd.gen_load  = pass_rd && (col_q >= CW'(1)) && (col_q <= ew_c);
				cmd.gen_wr    = pass_wr && (col_q >= CW'(3));
				cmd.flip      = last_col && last_pass;
			end
			ST_RESP: begin
				cmd.rsp_load = sts.rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q   <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.gen_start) begin
				col_q  <= '0;
				pass_q <= '0;
			end else if (state_q == ST_GEN) begin
				if (last_col) begin
					col_q  <= '0;
					pass_q <= pass_q + SW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (state_q == ST_IDLE) && !sts.dims_busy)
		else $error("item taken outside idle");
	a_flip_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flip |=> (state_q == ST_RESP))
		else $error("generation end did not reach response");
	a_wr_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_wr |-> (col_q >= CW'(3)) && (col_q <= ew_c + CW'(2)) && (pass_q <= eh))
		else $error("generation write outside its column window");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> sts.rsp_free)
		else $error("response loaded over a pending item");

endmodule

>>> hw/rtl/lca_dp.sv
// Datapath of the life step unit: grid dimensions, the two grid RAMs, the
// three row registers of the sweep, the B3/S23 rule and the response register.
// Depends on lca_pkg and lca_ram.
module lca_dp #(
	parameter int MAX_CELLS = 4096,
	parameter int MAX_SIDE  = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lca_pkg::cmd_t                      cmd,
	output lca_pkg::sts_t                      sts,
	output logic [$clog2(MAX_SIDE+1)-1:0]      ew,
	output logic [$clog2(MAX_SIDE+1)-1:0]      eh,
	input  logic [$clog2(MAX_SIDE+3)-1:0]      col,
	input  logic [lca_pkg::ACTION_W-1:0]       req_action,
	input  logic [lca_pkg::INDEX_W-1:0]        req_cell_index,
	input  logic                               req_cell_value,
	input  logic                               cfg_valid,
	input  logic [lca_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lca_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic                               rsp_read_value
);
	import lca_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE + 3);
	localparam int PW = 2 * SW;
	localparam int LW = $clog2(MAX_SIDE);
	localparam int XW = $clog2(MAX_SIDE + 2);
	localparam int DW = SW + CFG_DATA_W;

	function automatic logic [SW-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
		logic [DW-1:0] vx;
		vx = DW'(v);
		if (v == '0) clamp_side = SW'(1);
		else if (vx > DW'(MAX_SIDE)) clamp_side = SW'(MAX_SIDE);
		else clamp_side = SW'(v);
	endfunction

	// Dimensions: clamp, then trim rows until the grid fits the buffers
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [SW-1:0]         ew_q, eh_q;
	logic [PW-1:0]         cells_q;
	logic [PW-1:0]         prod;
	logic                  start_q, busy_q;

	assign prod = PW'(ew_q) * PW'(eh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIDE;
			height_q <= RESET_SIDE;
			ew_q     <= SW'(1);
			eh_q     <= SW'(1);
			cells_q  <= PW'(1);
			start_q  <= 1'b1;
			busy_q   <= 1'b1;
		end else begin
			if (cfg_valid && (cfg_index == REG_GRID_WIDTH)) begin
				width_q <= cfg_data;
				start_q <= 1'b1;
				busy_q  <= 1'b1;
			end else if (cfg_valid && (cfg_index == REG_GRID_HEIGHT)) begin
				height_q <= cfg_data;
				start_q  <= 1'b1;
				busy_q   <= 1'b1;
			end else if (start_q) begin
				ew_q    <= clamp_side(width_q);
				eh_q    <= clamp_side(height_q);
				start_q <= 1'b0;
			end else if (busy_q) begin
				if (32'(prod) > 32'(MAX_CELLS)) begin
					eh_q <= eh_q - SW'(1);
				end else begin
					cells_q <= prod;
					busy_q  <= 1'b0;
				end
			end
		end
	end

	assign ew = ew_q;
	assign eh = eh_q;

	// Buffers and sweep addresses
	logic          active_q;
	logic [AW-1:0] rd_addr_q, wr_addr_q;
	logic [AW-1:0] item_addr;
	logic          in_range;
	logic          acc_wr, acc_rd;
	logic          we_a, we_b, re_a, re_b;
	logic          wdata_a, wdata_b;
	logic          rdata_a, rdata_b, rdata_cur;
	logic [AW-1:0] waddr, raddr;
	logic          new_cell;

	assign item_addr = AW'(req_cell_index);
	assign in_range  = (32'(req_cell_index) < 32'(cells_q));
	assign acc_wr    = cmd.acc && (req_action == ACT_WRITE) && in_range;
	assign acc_rd    = cmd.acc && (req_action == ACT_READ) && in_range;

	assign we_a = cmd.clear_wr || (acc_wr && !active_q) || (cmd.gen_wr && active_q);
	assign we_b = cmd.clear_wr || (acc_wr && active_q) || (cmd.gen_wr && !active_q);
	assign re_a = (acc_rd || cmd.gen_rd) && !active_q;
	assign re_b = (acc_rd || cmd.gen_rd) && active_q;

	assign wdata_a = cmd.clear_wr ? 1'b0 : (cmd.gen_wr ? new_cell : req_cell_value);
	assign wdata_b = wdata_a;
	assign waddr   = (cmd.clear_wr || cmd.gen_wr) ? wr_addr_q : item_addr;
	assign raddr   = cmd.gen_rd ? rd_addr_q : item_addr;
	assign rdata_cur = active_q ? rdata_b : rdata_a;

	lca_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata_a),
		.re    (re_a),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	lca_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata_b),
		.re    (re_b),
		.raddr (raddr),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			rd_addr_q <= '0;
			wr_addr_q <= '0;
		end else begin
			if (cmd.flip) active_q <= !active_q;
			if (cmd.gen_start) begin
				rd_addr_q <= '0;
				wr_addr_q <= '0;
			end else begin
				if (cmd.gen_rd) rd_addr_q <= rd_addr_q + AW'(1);
				if (cmd.clear_wr || cmd.gen_wr) wr_addr_q <= wr_addr_q + AW'(1);
			end
		end
	end

	// Row window: r0 above, r1 the row being written, r2 the row being read
	logic [MAX_SIDE-1:0] r0_q, r1_q, r2_q;
	logic [MAX_SIDE+1:0] p0, p1, p2;
	logic [XW-1:0]       i0, i1, i2;
	logic [LW-1:0]       load_idx;
	logic [3:0]          nbr;

	assign p0 = {1'b0, r0_q, 1'b0};
	assign p1 = {1'b0, r1_q, 1'b0};
	assign p2 = {1'b0, r2_q, 1'b0};
	assign i0 = XW'(col - CW'(3));
	assign i1 = XW'(col - CW'(2));
	assign i2 = XW'(col - CW'(1));
	assign load_idx = LW'(col - CW'(1));

	assign nbr = 4'(p0[i0]) + 4'(p0[i1]) + 4'(p0[i2])
	           + 4'(p1[i0]) + 4'(p1[i2])
	           + 4'(p2[i0]) + 4'(p2[i1]) + 4'(p2[i2]);
	assign new_cell = (nbr == 4'd3) || (p1[i1] && (nbr == 4'd2));

	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
		end else if (cmd.row_shift) begin
			r0_q <= r1_q;
			r1_q <= r2_q;
			r2_q <= '0;
		end else if (cmd.gen_load) begin
			r2_q[load_idx] <= rdata_cur;
		end
	end

	// Response register
	logic                act_q;
	logic                range_q;
	logic                rsp_valid_q;
	logic                rsp_value_q;

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			act_q   <= (req_action == ACT_READ);
			range_q <= in_range;
		end
		if (cmd.rsp_load) begin
			rsp_value_q <= act_q && range_q && rdata_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_read_value = rsp_value_q;

	assign sts.clear_last = (wr_addr_q == AW'(MAX_CELLS - 1));
	assign sts.dims_busy  = start_q || busy_q;
	assign sts.rsp_free   = !rsp_valid_q || rsp_ready;

endmodule

>>> hw/rtl/life_cellular_automaton_step_unit.sv
// Game of Life (B3/S23) step unit: top level joining controller and datapath.
// Depends on lca_pkg, lca_if, lca_ctrl, lca_dp (and lca_ram below it).
//
// After reset the unit sweeps both grid buffers to all-dead, one cell of each
// per cycle, and takes no request item until that pass ends; configuration
// writes are taken at any time. Each grid_width/grid_height write starts a
// short recompute of the grid shape (clamp, then one row trimmed per cycle
// while width*height exceeds MAX_CELLS) that also holds off requests. Items are
// handled one at a time. A write or read goes from acceptance to the response
// state, where it waits until the response register is free to load, the read
// served by the registered port of the active buffer's RAM. An advance sweeps
// the grid row by row in height+1 passes, each reading the next row, if any,
// while it writes the row before it, with at most one read of the current
// buffer and one write of the other buffer per cycle. Every item gives exactly
// one response item.
module life_cellular_automaton_step_unit #(
	parameter int MAX_CELLS = 4096,
	parameter int MAX_SIDE  = 64
) (
	input logic       clk,
	input logic       arst_n,
	lca_req_if.sink   req,
	lca_rsp_if.source rsp,
	lca_cfg_if.sink   cfg
);
	import lca_pkg::*;

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE + 3);

	cmd_t          cmd;
	sts_t          sts;
	logic [SW-1:0] ew, eh;
	logic [CW-1:0] col;
	logic          cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	lca_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.sts        (sts),
		.ew         (ew),
		.eh         (eh),
		.cmd        (cmd),
		.col        (col)
	);

	lca_dp #(.MAX_CELLS(MAX_CELLS), .MAX_SIDE(MAX_SIDE)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.ew             (ew),
		.eh             (eh),
		.col            (col),
		.req_action     (req.action),
		.req_cell_index (req.cell_index),
		.req_cell_value (req.cell_value),
		.cfg_valid      (cfg_wr),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_read_value (rsp.read_value)
	);

endmodule

>>> tb/sv/tb.sv
// Testbench for life_cellular_automaton_step_unit: cell writes, cell reads and
// generation steps over several grid shapes, checked against a B3/S23 grid model.
// Depends on lca_pkg, lca_if and the unit's RTL.
module tb;
	import lca_pkg::*;

	localparam int MAX_CELLS    = 4096;
	localparam int MAX_SIDE     = 64;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 140;
	localparam int TAIL_ITEMS   = 110;
	localparam int DRAIN_CYCLES = 50;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet_tail = 1'b0;
	int   cycles = 0;
	int   config_writes = 0;
	int   shapes = 0;

	lca_req_if req_ch();
	lca_rsp_if rsp_ch();
	lca_cfg_if cfg_ch();

	life_cellular_automaton_step_unit #(
		.MAX_CELLS(MAX_CELLS),
		.MAX_SIDE(MAX_SIDE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	class life_grid_model;
		bit cells[2][MAX_CELLS];
		bit active;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		bit expected_reads[$];
		int errors;
		int responses;
		int generations;
		int reads;

		function new();
			width_reg = RESET_SIDE;
			height_reg = RESET_SIDE;
			active = 1'b0;
		endfunction

		// clamp each side, then trim rows while the grid exceeds storage
		function void grid_dims(output int w, output int h);
			w = (width_reg == 0) ? 1 : (width_reg > MAX_SIDE) ? MAX_SIDE : int'(width_reg);
			h = (height_reg == 0) ? 1 : (height_reg > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
			if (w * h > MAX_CELLS)
				h = MAX_CELLS / w;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
			REG_GRID_WIDTH: width_reg = data;
			REG_GRID_HEIGHT: height_reg = data;
			default: ;
			endcase
		endfunction

		function void note_item(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx, logic val);
			int w, h, n, x, y, dx, dy, nx, ny;
			bit result;
			grid_dims(w, h);
			result = 1'b0;
			case (act)
			ACT_WRITE: begin
				if (idx < w * h)
					cells[active][idx] = val;
			end
			ACT_READ: begin
				if (idx < w * h)
					result = cells[active][idx];
				reads++;
			end
			ACT_ADVANCE: begin
				// cells past w*h in the other buffer are left as they are
				for (y = 0; y < h; y++) begin
					for (x = 0; x < w; x++) begin
						n = 0;
						for (dy = -1; dy <= 1; dy++) begin
							for (dx = -1; dx <= 1; dx++) begin
								nx = x + dx;
								ny = y + dy;
								if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h)
									n += cells[active][ny * w + nx];
							end
						end
						if (cells[active][y * w + x])
							cells[!active][y * w + x] = (n == 2 || n == 3);
						else
							cells[!active][y * w + x] = (n == 3);
					end
				end
				active = !active;
				generations++;
			end
			default: ;
			endcase
			expected_reads.push_back(result);
		endfunction

		function void check_item(logic got);
			bit want;
			responses++;
			if (expected_reads.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("response %0d arrived with nothing outstanding, read_value=%b",
						responses, got);
			end else begin
				want = expected_reads.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("response %0d read_value mismatch: expected %0b, got %b",
							responses, want, got);
				end
			end
		endfunction
	endclass

	life_grid_model grid_model;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			grid_model.note_item(req_ch.action, req_ch.cell_index, req_ch.cell_value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			grid_model.check_item(rsp_ch.read_value);
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			grid_model.set_reg(cfg_ch.index, cfg_ch.data);
	end

	// response backpressure: random stall bursts, none in the tail
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		forever begin
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				repeat (n) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// leave valid high on return so back-to-back items need no drop
	task automatic send_item(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx, logic val);
		int gap;
		if (!quiet_tail && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 9);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.cell_index <= idx;
		req_ch.cell_value <= val;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		config_writes++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (grid_model.expected_reads.size() != 0)
			@(posedge clk);
	endtask

	// mostly a cell inside the grid, now and then any index
	function automatic logic [INDEX_W-1:0] pick_cell();
		int w, h;
		grid_model.grid_dims(w, h);
		if ($urandom_range(0, 7) == 0)
			return INDEX_W'($urandom_range(0, MAX_CELLS - 1));
		return INDEX_W'($urandom_range(0, w * h - 1));
	endfunction

	task automatic send_noise();
		logic [ACTION_W-1:0] act;
		int w, h;
		grid_model.grid_dims(w, h);
		act = ACTION_W'($urandom_range(0, 3));
		// keep full-size sweeps rare
		if (act == ACT_ADVANCE && w * h > 1024)
			act = ACT_UNUSED;
		send_item(act, INDEX_W'($urandom_range(0, MAX_CELLS - 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int w, h, sel, n_writes, n_gens, n_reads, random_items, big_shapes;
		logic [CFG_DATA_W-1:0] wv, hv, wide_side, thin_side;
		grid_model = new();
		random_items = 0;
		big_shapes = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_WRITE;
		req_ch.cell_index = '0;
		req_ch.cell_value = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GRID_WIDTH;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full 64 by 64 grid from reset: corners, a row of four cells on the top edge
		send_item(ACT_READ, 12'd0, 1'b0);
		send_item(ACT_READ, 12'd4095, 1'b1);
		send_item(ACT_WRITE, 12'd4095, 1'b1);
		send_item(ACT_READ, 12'd4095, 1'b0);
		send_item(ACT_WRITE, 12'd0, 1'b1);
		send_item(ACT_WRITE, 12'd1, 1'b1);
		send_item(ACT_WRITE, 12'd2, 1'b1);
		send_item(ACT_WRITE, 12'd3, 1'b1);
		send_item(ACT_UNUSED, 12'd2, 1'b1);
		send_item(ACT_ADVANCE, 12'd0, 1'b0);
		send_item(ACT_READ, 12'd0, 1'b0);
		send_item(ACT_READ, 12'd2, 1'b0);
		send_item(ACT_READ, 12'd66, 1'b0);
		send_item(ACT_READ, 12'd4095, 1'b0);
		wait_idle();

		// zero width and oversized height clamp to a 1 by 64 column
		set_register(REG_GRID_WIDTH, 7'd0);
		set_register(REG_GRID_HEIGHT, 7'd127);
		shapes++;
		send_item(ACT_WRITE, 12'd10, 1'b1);
		send_item(ACT_WRITE, 12'd11, 1'b1);
		send_item(ACT_WRITE, 12'd12, 1'b1);
		send_item(ACT_WRITE, 12'd64, 1'b1);
		send_item(ACT_READ, 12'd64, 1'b0);
		send_item(ACT_ADVANCE, 12'd4095, 1'b1);
		send_item(ACT_READ, 12'd10, 1'b0);
		send_item(ACT_READ, 12'd11, 1'b0);
		send_item(ACT_READ, 12'd4095, 1'b0);
		wait_idle();

		// seed a pattern, step it, read it back; a few stray items mixed in
		while (random_items < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0 && big_shapes < 2) begin
				wv = RESET_SIDE;
				hv = RESET_SIDE;
				big_shapes++;
			end else if (sel <= 2) begin
				wide_side = ($urandom_range(0, 2) == 0) ? 7'd127
					: CFG_DATA_W'($urandom_range(MAX_SIDE, 127));
				thin_side = CFG_DATA_W'($urandom_range(0, 2));
				if ($urandom_range(0, 1) == 0) begin
					wv = wide_side;
					hv = thin_side;
				end else begin
					wv = thin_side;
					hv = wide_side;
				end
			end else begin
				wv = CFG_DATA_W'($urandom_range(1, 12));
				hv = CFG_DATA_W'($urandom_range(1, 12));
			end
			set_register(REG_GRID_WIDTH, wv);
			set_register(REG_GRID_HEIGHT, hv);
			shapes++;
			grid_model.grid_dims(w, h);

			n_writes = $urandom_range(2, (w * h < 13) ? w * h + 1 : 14);
			repeat (n_writes) begin
				if ($urandom_range(0, 5) == 0)
					send_noise();
				send_item(ACT_WRITE, pick_cell(), $urandom_range(0, 3) != 0);
				random_items++;
			end
			n_gens = (w * h > 1024) ? 1 : $urandom_range(1, 3);
			repeat (n_gens) begin
				send_item(ACT_ADVANCE, INDEX_W'($urandom_range(0, MAX_CELLS - 1)),
					1'($urandom_range(0, 1)));
				random_items++;
				repeat ($urandom_range(0, 2)) begin
					send_item(ACT_READ, pick_cell(), 1'($urandom_range(0, 1)));
					random_items++;
				end
			end
			n_reads = $urandom_range(3, 8);
			repeat (n_reads) begin
				if ($urandom_range(0, 5) == 0)
					send_noise();
				send_item(ACT_READ, pick_cell(), 1'($urandom_range(0, 1)));
				random_items++;
			end
			if (random_items >= TAIL_ITEMS)
				quiet_tail = 1'b1;
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d grid shapes with %0d register writes and %0d generation steps;",
			shapes, config_writes, grid_model.generations);
		$display("checked %0d responses, %0d of them cell reads, %0d errors.",
			grid_model.responses, grid_model.reads, grid_model.errors);
		if (grid_model.errors == 0 && grid_model.expected_reads.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
